// ===== hw/rtl/cdeq_pkg.sv =====
package cdeq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int WORD_W = 32;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W = 4;

    localparam logic [OPCODE_W-1:0] OP_INSERT_REAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_REAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT_FRONT = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_FRONT = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic push_front;
        logic pop_front;
        logic push_rear;
        logic pop_rear;
    } cdeq_ctrl_t;

endpackage

// ===== hw/rtl/cdeq_cell.sv =====
module cdeq_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdeq_pkg::cdeq_ctrl_t              ctrl,
    input  logic [cdeq_pkg::WORD_W-1:0]       value_in,
    input  logic                              left_valid,
    input  logic [cdeq_pkg::WORD_W-1:0]       left_data,
    input  logic                              right_valid,
    input  logic [cdeq_pkg::WORD_W-1:0]       right_data,
    output logic                              valid,
    output logic [cdeq_pkg::WORD_W-1:0]       data,
    output logic [cdeq_pkg::WORD_W-1:0]       rear_tap
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [cdeq_pkg::WORD_W-1:0]   data_reg;
    logic [cdeq_pkg::WORD_W-1:0]   data_next;
    logic                          is_rear;

    assign is_rear = valid_reg && !right_valid;

    always_comb
    begin
        valid_next = valid_reg;
        data_next = data_reg;
        if (ctrl.push_front)
        begin
            valid_next = left_valid;
            data_next = left_data;
        end
        else if (ctrl.pop_front)
        begin
            valid_next = right_valid;
            data_next = right_data;
        end
        else if (ctrl.push_rear)
        begin
            if (!valid_reg && left_valid)
            begin
                valid_next = 1'b1;
                data_next = value_in;
            end
        end
        else if (ctrl.pop_rear)
        begin
            if (is_rear)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data = data_reg;
    assign rear_tap = data_reg & {cdeq_pkg::WORD_W{is_rear}};

endmodule

// ===== hw/rtl/circular_double_ended_queue_core.sv =====
// each accepted word's result word is registered in the output register
// throughput: one word per cycle while the result side keeps taking words
// the front is always the first cell of the chain, the rear is the last occupied cell
// reset clears the occupancy count, every cell's valid bit and the output valid
// stored data words are not cleared; no clearing pass is needed after reset
module circular_double_ended_queue_core
#(
    parameter int DEPTH = cdeq_pkg::DEPTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cdeq_pkg::OPCODE_W-1:0]       opcode,
    input  logic signed [cdeq_pkg::WORD_W-1:0]  value_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cdeq_pkg::WORD_W-1:0]  value_out,
    output logic [cdeq_pkg::STATUS_W-1:0]       status,
    output logic [cdeq_pkg::FILL_W-1:0]         fill_level,
    output logic                                now_empty,
    output logic                                now_full
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int W = cdeq_pkg::WORD_W;

    logic                         in_fire;
    logic                         is_insert;
    logic                         is_front;
    logic                         q_empty;
    logic                         q_full;
    logic                         rejected;
    cdeq_pkg::cdeq_ctrl_t         ctrl;

    logic [OCC_W-1:0]             occ_reg;
    logic [OCC_W-1:0]             occ_next;
    logic                         out_valid_reg;
    logic [W-1:0]                 value_reg;
    logic [W-1:0]                 value_next;
    logic [cdeq_pkg::STATUS_W-1:0] status_reg;
    logic [cdeq_pkg::STATUS_W-1:0] status_next;
    logic [OCC_W+cdeq_pkg::FILL_W-1:0] occ_ext;

    logic [DEPTH-1:0]             cell_valid;
    logic [W-1:0]                 cell_data [DEPTH];
    logic [W-1:0]                 cell_tap [DEPTH];
    logic [W-1:0]                 rear_data;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire = in_valid && in_ready;
    assign is_insert = (opcode == cdeq_pkg::OP_INSERT_REAR)
                    || (opcode == cdeq_pkg::OP_INSERT_FRONT);
    assign is_front = (opcode == cdeq_pkg::OP_INSERT_FRONT)
                   || (opcode == cdeq_pkg::OP_REMOVE_FRONT);
    assign q_empty = (occ_reg == '0);
    assign q_full = (occ_reg == OCC_W'(DEPTH));
    assign rejected = is_insert ? q_full : q_empty;

    always_comb
    begin
        ctrl = '0;
        if (in_fire && !rejected)
        begin
            case (opcode)
                cdeq_pkg::OP_INSERT_REAR:  ctrl.push_rear = 1'b1;
                cdeq_pkg::OP_REMOVE_REAR:  ctrl.pop_rear = 1'b1;
                cdeq_pkg::OP_INSERT_FRONT: ctrl.push_front = 1'b1;
                cdeq_pkg::OP_REMOVE_FRONT: ctrl.pop_front = 1'b1;
                default:                   ctrl = '0;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic         lv;
            logic [W-1:0] ld;
            logic         rv;
            logic [W-1:0] rd;
            if (gi == 0)
            begin : g_first
                assign lv = 1'b1;
                assign ld = value_in;
            end
            else
            begin : g_mid_l
                assign lv = cell_valid[gi-1];
                assign ld = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign rv = 1'b0;
                assign rd = '0;
            end
            else
            begin : g_mid_r
                assign rv = cell_valid[gi+1];
                assign rd = cell_data[gi+1];
            end
            cdeq_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .value_in    (value_in),
                .left_valid  (lv),
                .left_data   (ld),
                .right_valid (rv),
                .right_data  (rd),
                .valid       (cell_valid[gi]),
                .data        (cell_data[gi]),
                .rear_tap    (cell_tap[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rear_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_data = rear_data | cell_tap[i];
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        value_next = '0;
        status_next = cdeq_pkg::ST_DONE;
        if (rejected)
        begin
            status_next = is_insert ? cdeq_pkg::ST_FULL : cdeq_pkg::ST_EMPTY;
        end
        else if (is_insert)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else
        begin
            occ_next = occ_reg - OCC_W'(1);
            value_next = is_front ? cell_data[0] : rear_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                occ_reg <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            value_reg <= value_next;
            status_reg <= status_next;
        end
    end

    assign occ_ext = {{cdeq_pkg::FILL_W{1'b0}}, occ_reg};
    assign out_valid = out_valid_reg;
    assign value_out = value_reg;
    assign status = status_reg;
    assign fill_level = occ_ext[cdeq_pkg::FILL_W-1:0];
    assign now_empty = (occ_reg == '0);
    assign now_full = (occ_reg == OCC_W'(DEPTH));

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(occ_reg))
        else $error("cell valid bits disagree with occupancy");

    a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[0] == (occ_reg != '0))
        else $error("front cell valid disagrees with occupancy");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted word produced no result");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == cdeq_pkg::ST_FULL) |-> now_full)
        else $error("full rejection while not full");

endmodule

// ===== tb/tb_circular_double_ended_queue_core.sv =====
`timescale 1ns / 100ps

module tb_circular_double_ended_queue_core;

    localparam int DEPTH = cdeq_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 120;

    typedef struct packed {
        logic signed [cdeq_pkg::WORD_W-1:0] value;
        logic [cdeq_pkg::STATUS_W-1:0]      status;
        logic [cdeq_pkg::FILL_W-1:0]        fill;
        logic                               empty;
        logic                               full;
    } deque_result_t;

    class deque_scoreboard;
        logic signed [cdeq_pkg::WORD_W-1:0] contents[$];
        deque_result_t                      expected_words[$];
        int                                 errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_input(logic [cdeq_pkg::OPCODE_W-1:0] op,
                                 logic signed [cdeq_pkg::WORD_W-1:0] v);
            deque_result_t r;
            r.value  = '0;
            r.status = cdeq_pkg::ST_DONE;
            if (op == cdeq_pkg::OP_INSERT_REAR || op == cdeq_pkg::OP_INSERT_FRONT)
            begin
                if (contents.size() >= DEPTH)
                    r.status = cdeq_pkg::ST_FULL;
                else if (op == cdeq_pkg::OP_INSERT_REAR)
                    contents.push_back(v);
                else
                    contents.push_front(v);
            end
            else
            begin
                if (contents.size() == 0)
                    r.status = cdeq_pkg::ST_EMPTY;
                else if (op == cdeq_pkg::OP_REMOVE_REAR)
                    r.value = contents.pop_back();
                else
                    r.value = contents.pop_front();
            end
            r.fill  = cdeq_pkg::FILL_W'(contents.size());
            r.empty = (contents.size() == 0);
            r.full  = (contents.size() == DEPTH);
            expected_words.push_back(r);
        endfunction

        function void check_result(deque_result_t got);
            deque_result_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: value %0d status %0d fill %0d",
                             got.value, got.status, got.fill);
                return;
            end
            want = expected_words.pop_front();
            if (got.value !== want.value || got.status !== want.status ||
                got.fill !== want.fill || got.empty !== want.empty ||
                got.full !== want.full)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: exp value %0d status %0d fill %0d empty %0b full %0b",
                             want.value, want.status, want.fill, want.empty, want.full);
                    $display("          act value %0d status %0d fill %0d empty %0b full %0b",
                             got.value, got.status, got.fill, got.empty, got.full);
                end
            end
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [cdeq_pkg::OPCODE_W-1:0]      opcode = cdeq_pkg::OP_INSERT_REAR;
    logic signed [cdeq_pkg::WORD_W-1:0] value_in = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [cdeq_pkg::WORD_W-1:0] value_out;
    logic [cdeq_pkg::STATUS_W-1:0]      status;
    logic [cdeq_pkg::FILL_W-1:0]        fill_level;
    logic                               now_empty;
    logic                               now_full;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    deque_scoreboard sb = new();

    circular_double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .value_in(value_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .value_out(value_out),
        .status(status),
        .fill_level(fill_level),
        .now_empty(now_empty),
        .now_full(now_full)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_circular_double_ended_queue_core: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({value_out, status, fill_level, now_empty, now_full});
    end

    task automatic send_word(input logic [cdeq_pkg::OPCODE_W-1:0] op,
                             input logic signed [cdeq_pkg::WORD_W-1:0] v);
        logic accepted;
        accepted = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value_in <= v;
        // ready is stable mid-cycle, so sample it before the edge
        while (!accepted)
        begin
            @(negedge clk);
            accepted = in_ready;
            @(posedge clk);
        end
        sb.note_input(op, v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        // both removals on an empty deque
        send_word(cdeq_pkg::OP_REMOVE_REAR, $urandom);
        send_word(cdeq_pkg::OP_REMOVE_FRONT, $urandom);
        // fill from both ends until full, starting with extreme values
        send_word(cdeq_pkg::OP_INSERT_REAR, 32'sh7fffffff);
        send_word(cdeq_pkg::OP_INSERT_FRONT, 32'sh80000000);
        send_word(cdeq_pkg::OP_INSERT_REAR, 32'sh00000000);
        send_word(cdeq_pkg::OP_INSERT_FRONT, 32'shffffffff);
        send_word(cdeq_pkg::OP_INSERT_REAR, 32'shaaaaaaaa);
        send_word(cdeq_pkg::OP_INSERT_FRONT, 32'sh55555555);
        send_word(cdeq_pkg::OP_INSERT_REAR, 32'sh00000001);
        send_word(cdeq_pkg::OP_INSERT_FRONT, 32'sh00000002);
        // inserts when full
        send_word(cdeq_pkg::OP_INSERT_REAR, $urandom);
        send_word(cdeq_pkg::OP_INSERT_FRONT, $urandom);
        // empty it from alternating ends
        repeat (4)
        begin
            send_word(cdeq_pkg::OP_REMOVE_FRONT, $urandom);
            send_word(cdeq_pkg::OP_REMOVE_REAR, $urandom);
        end
        send_word(cdeq_pkg::OP_REMOVE_REAR, $urandom);
        // front insert into an empty deque
        send_word(cdeq_pkg::OP_INSERT_FRONT, 32'sh00000003);
        send_word(cdeq_pkg::OP_REMOVE_FRONT, $urandom);
    endtask

    task automatic run_random(input int count);
        int insert_pct;
        logic [cdeq_pkg::OPCODE_W-1:0] op;
        logic signed [cdeq_pkg::WORD_W-1:0] v;
        insert_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            // drift toward full or empty in bursts
            if (i % 16 == 0)
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            if ($urandom_range(99) < insert_pct)
                op = $urandom_range(1) ? cdeq_pkg::OP_INSERT_FRONT
                                       : cdeq_pkg::OP_INSERT_REAR;
            else
                op = $urandom_range(1) ? cdeq_pkg::OP_REMOVE_FRONT
                                       : cdeq_pkg::OP_REMOVE_REAR;
            if ($urandom_range(9) == 0)
                case ($urandom_range(3))
                    0: v = 32'sh00000000;
                    1: v = 32'shffffffff;
                    2: v = 32'sh80000000;
                    default: v = 32'sh7fffffff;
                endcase
            else
                v = $urandom;
            send_word(op, v);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            run_random(PHASE_WORDS);
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_circular_double_ended_queue_core: clean");
        else
            $display("tb_circular_double_ended_queue_core: errors");
        $finish;
    end

endmodule

// ===== circular_double_ended_queue_core.f =====
hw/rtl/cdeq_pkg.sv
hw/rtl/cdeq_cell.sv
hw/rtl/circular_double_ended_queue_core.sv
tb/tb_circular_double_ended_queue_core.sv
